### rtl/core/sgd_pkg.sv
package sgd_pkg;

    localparam int MaxWidth      = 1024;
    localparam int MaxHeight     = 4096;
    localparam int CfgIdxW       = 1;
    localparam int CfgDataW      = 13;
    localparam int ImgWidthW     = 11;
    localparam int ImgHeightW    = 13;
    localparam int RowCountW     = 12;
    localparam int MagW          = 15;
    localparam int DirW          = 3;
    localparam int GradW         = 11;
    localparam int AbsW          = 10;
    localparam int SqW           = 30;
    localparam int QueueDepth    = 4;

    localparam logic [ImgWidthW-1:0]  WidthReset  = 11'd640;
    localparam logic [ImgHeightW-1:0] HeightReset = 13'd480;

    localparam logic [CfgIdxW-1:0] RegImageWidth  = 1'b0;
    localparam logic [CfgIdxW-1:0] RegImageHeight = 1'b1;

    localparam logic [DirW-1:0] DirHorizontal = 3'd1;
    localparam logic [DirW-1:0] DirDiagUp     = 3'd2;
    localparam logic [DirW-1:0] DirVertical   = 3'd3;
    localparam logic [DirW-1:0] DirDiagDown   = 3'd4;

    typedef struct packed {
        logic [AbsW-1:0] abs_gx;
        logic [AbsW-1:0] abs_gy;
        logic [DirW-1:0] direction;
        logic            row_end;
        logic            frame_end;
    } grad_item_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_RUN,
        SQ_DONE
    } sqrt_state_t;

endpackage

### rtl/core/sgd_front.sv
module sgd_front
    import sgd_pkg::*;
#(
    parameter int MAX_WIDTH = MaxWidth
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    input  logic [7:0]            pix,
    input  logic                  frame_start,
    input  logic [ImgWidthW-1:0]  image_width,
    input  logic [ImgHeightW-1:0] image_height,
    output logic                  item_valid,
    output grad_item_t            item
);

    localparam int ColW = $clog2(MAX_WIDTH + 1);
    localparam int AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [7:0] near_mem [MAX_WIDTH];
    logic [7:0] far_mem  [MAX_WIDTH];

    logic [ColW-1:0]      col_reg, col_next, col_eff;
    logic [RowCountW:0]   row_reg, row_next, row_eff;
    logic [7:0]           win_reg [9];
    logic [7:0]           top_reg, mid_reg, px_reg;
    logic                 s1_valid_reg, s1_int_reg, s1_rend_reg, s1_fend_reg;
    logic                 s2_valid_reg;
    grad_item_t           s2_item_reg;
    logic [AddrW-1:0]     addr;
    logic [ColW-1:0]      w_eff;
    logic [RowCountW:0]   h_eff;
    logic                 interior, row_end, frame_end;

    always_comb
    begin
        if ({2'b0, image_width} < 13'd3)
            w_eff = ColW'(3);
        else if (32'(image_width) > MAX_WIDTH)
            w_eff = ColW'(MAX_WIDTH);
        else
            w_eff = ColW'(image_width);
        if (image_height < 13'd3)
            h_eff = 13'd3;
        else if (image_height > 13'(MaxHeight))
            h_eff = 13'(MaxHeight);
        else
            h_eff = image_height;
        col_eff = frame_start ? '0 : col_reg;
        row_eff = frame_start ? '0 : row_reg;
        addr = AddrW'(col_eff);
        interior = (col_eff >= ColW'(2)) && (row_eff >= 13'd2)
                && (col_eff <= w_eff - ColW'(1)) && (row_eff <= h_eff - 13'd1);
        row_end = (col_eff == w_eff - ColW'(1));
        frame_end = row_end && (row_eff == h_eff - 13'd1);
        if (col_eff + ColW'(1) >= w_eff)
        begin
            col_next = '0;
            row_next = (row_eff + 13'd1 >= h_eff) ? '0 : row_eff + 13'd1;
        end
        else
        begin
            col_next = col_eff + ColW'(1);
            row_next = row_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_valid)
        begin
            far_mem[addr]  <= near_mem[addr];
            near_mem[addr] <= pix;
            top_reg <= far_mem[addr];
            mid_reg <= near_mem[addr];
            px_reg  <= pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            s1_valid_reg <= 1'b0;
            s1_int_reg <= 1'b0;
            s1_rend_reg <= 1'b0;
            s1_fend_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            s1_valid_reg <= pix_valid;
            if (pix_valid)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                s1_int_reg <= interior;
                s1_rend_reg <= row_end;
                s1_fend_reg <= frame_end;
            end
            if (s1_valid_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= top_reg;
                win_reg[5] <= mid_reg;
                win_reg[8] <= px_reg;
            end
            s2_valid_reg <= s1_valid_reg && s1_int_reg;
        end
    end

    logic signed [GradW-1:0] gx, gy;
    logic [AbsW-1:0]         ax, ay;
    logic [2*AbsW+1:0]       sum_sq, dif_sq, two_bx;
    logic [AbsW:0]           s_ab, d_ab;
    logic [DirW-1:0]         dir;

    always_comb
    begin
        gx = (GradW'(top_reg) + (GradW'(mid_reg) << 1) + GradW'(px_reg))
           - (GradW'(win_reg[1]) + (GradW'(win_reg[4]) << 1) + GradW'(win_reg[7]));
        gy = (GradW'(win_reg[1]) + (GradW'(win_reg[2]) << 1) + GradW'(top_reg))
           - (GradW'(win_reg[7]) + (GradW'(win_reg[8]) << 1) + GradW'(px_reg));
        ax = gx[GradW-1] ? AbsW'(-gx) : AbsW'(gx);
        ay = gy[GradW-1] ? AbsW'(-gy) : AbsW'(gy);
        s_ab = {1'b0, ay} + {1'b0, ax};
        d_ab = {1'b0, ay} - {1'b0, ax};
        sum_sq = (2*AbsW+2)'(s_ab * s_ab);
        dif_sq = (2*AbsW+2)'(d_ab * d_ab);
        two_bx = (2*AbsW+2)'({ax, 1'b0} * ax);
        if (sum_sq < two_bx || (ax == '0 && ay == '0))
            dir = DirHorizontal;
        else if (ay > ax && dif_sq > two_bx)
            dir = DirVertical;
        else if (gx[GradW-1] == gy[GradW-1])
            dir = DirDiagUp;
        else
            dir = DirDiagDown;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_int_reg)
        begin
            s2_item_reg.abs_gx <= ax;
            s2_item_reg.abs_gy <= ay;
            s2_item_reg.direction <= dir;
            s2_item_reg.row_end <= s1_rend_reg;
            s2_item_reg.frame_end <= s1_fend_reg;
        end
    end

    assign item_valid = s2_valid_reg;
    assign item = s2_item_reg;

endmodule

### rtl/core/sgd_queue.sv
module sgd_queue
    import sgd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  grad_item_t push_item,
    input  logic       pop,
    output logic       not_empty,
    output logic       almost_full,
    output grad_item_t head
);

    localparam int PtrW = $clog2(QueueDepth);

    grad_item_t        mem_reg [QueueDepth];
    logic [PtrW-1:0]   wr_reg, rd_reg;
    logic [PtrW:0]     cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + PtrW'(1);
            if (pop)
                rd_reg <= rd_reg + PtrW'(1);
            cnt_reg <= cnt_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end

    assign not_empty = (cnt_reg != '0);
    assign almost_full = (cnt_reg >= (PtrW+1)'(QueueDepth - 3));
    assign head = mem_reg[rd_reg];

endmodule

### rtl/core/sgd_back.sv
module sgd_back
    import sgd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  grad_item_t      in_item,
    output logic            in_take,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [MagW-1:0] magnitude,
    output logic [DirW-1:0] direction,
    output logic            row_end,
    output logic            frame_end
);

    localparam int StepW = $clog2(MagW + 1);

    sqrt_state_t       state_reg, state_next;
    logic [SqW-1:0]    rem_reg, rem_next;
    logic [SqW-1:0]    val_reg, val_next;
    logic [MagW-1:0]   root_reg, root_next;
    logic [StepW-1:0]  step_reg, step_next;
    logic [DirW-1:0]   dir_reg;
    logic              rend_reg, fend_reg;
    logic [SqW-1:0]    sq_x, sq_y;
    logic [SqW+1:0]    trial, rem_sh;

    assign sq_x = SqW'(in_item.abs_gx * in_item.abs_gx);
    assign sq_y = SqW'(in_item.abs_gy * in_item.abs_gy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        val_reg <= val_next;
        root_reg <= root_next;
        step_reg <= step_next;
        if (in_take)
        begin
            dir_reg <= in_item.direction;
            rend_reg <= in_item.row_end;
            fend_reg <= in_item.frame_end;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rem_next = rem_reg;
        val_next = val_reg;
        root_next = root_reg;
        step_next = step_reg;
        in_take = 1'b0;
        rem_sh = {rem_reg, val_reg[SqW-1 -: 2]};
        trial = (SqW+2)'({root_reg, 2'b01});
        unique case (state_reg)
            SQ_IDLE:
            begin
                if (in_valid)
                begin
                    in_take = 1'b1;
                    val_next = (sq_x + sq_y) << 8;
                    rem_next = '0;
                    root_next = '0;
                    step_next = '0;
                    state_next = SQ_RUN;
                end
            end
            SQ_RUN:
            begin
                val_next = val_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_next = SqW'(rem_sh - trial);
                    root_next = {root_reg[MagW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = SqW'(rem_sh);
                    root_next = {root_reg[MagW-2:0], 1'b0};
                end
                step_next = step_reg + StepW'(1);
                if (step_reg == StepW'(MagW - 1))
                    state_next = SQ_DONE;
            end
            SQ_DONE:
            begin
                if (out_ready)
                    state_next = SQ_IDLE;
            end
            default:
                state_next = SQ_IDLE;
        endcase
    end

    assign out_valid = (state_reg == SQ_DONE);
    assign magnitude = root_reg;
    assign direction = dir_reg;
    assign row_end = rend_reg;
    assign frame_end = fend_reg;

endmodule

### rtl/core/sobel_gradient_direction.sv
// Sobel gradient magnitude and direction over a raster pixel stream. Pixels
// enter at one per clock while the queue is empty; the front end keeps two
// line stores and a 3x3 window and classifies the direction sector. The
// magnitude floor(16*sqrt(gx^2+gy^2)) comes from a bit-serial square root
// that handles one interior pixel at a time (load, 15 digit steps, output);
// border pixels produce no beat. A beat carries magnitude and direction in
// tdata, frame_end in tuser and row_end in tlast.
module sobel_gradient_direction
    import sgd_pkg::*;
#(
    parameter int MAX_WIDTH = MaxWidth
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,  // pixel
    input  logic                s_axis_tuser,  // frame_start
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata,  // magnitude[14:0], direction[17:15]
    output logic                m_axis_tuser,  // frame_end
    output logic                m_axis_tlast,  // row_end
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    logic [ImgWidthW-1:0]  width_reg;
    logic [ImgHeightW-1:0] height_reg;
    logic                  accept, f_valid, q_ne, q_af, q_pop;
    grad_item_t            f_item, q_head;
    logic [MagW-1:0]       mag;
    logic [DirW-1:0]       dir;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WidthReset;
            height_reg <= HeightReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegImageWidth:  width_reg <= cfg_data[ImgWidthW-1:0];
                RegImageHeight: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !q_af;
    assign accept = s_axis_tvalid && s_axis_tready;

    sgd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .pix_valid(accept), .pix(s_axis_tdata),
        .frame_start(s_axis_tuser), .image_width(width_reg),
        .image_height(height_reg), .item_valid(f_valid), .item(f_item)
    );

    sgd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(f_valid), .push_item(f_item),
        .pop(q_pop), .not_empty(q_ne), .almost_full(q_af), .head(q_head)
    );

    sgd_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(q_ne), .in_item(q_head),
        .in_take(q_pop), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .magnitude(mag), .direction(dir), .row_end(m_axis_tlast),
        .frame_end(m_axis_tuser)
    );

    assign m_axis_tdata = {6'b0, dir, mag};

endmodule

### sim/sobel_gradient_direction_tb.sv
`timescale 1ns / 100ps

module sobel_gradient_direction_tb;
    import sgd_pkg::*;

    typedef struct packed {
        logic [MagW-1:0] magnitude;
        logic [DirW-1:0] direction;
        logic            row_end;
        logic            frame_end;
    } gradient_t;

    localparam int CycleLimit = 2000000;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;   // pixel
    logic                s_axis_tuser;   // frame_start
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [23:0]         m_axis_tdata;   // magnitude[14:0], direction[17:15]
    logic                m_axis_tuser;   // frame_end
    logic                m_axis_tlast;   // row_end
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    logic [7:0]  near_row [MaxWidth];
    logic [7:0]  far_row  [MaxWidth];
    logic [7:0]  win [9];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned width_reg;
    int unsigned height_reg;

    gradient_t   expected_q [$];
    int          error_count;
    int          pixel_count;
    int          gradient_count;
    int          frame_count;
    int unsigned cycle_count;
    bit          src_steady;
    bit          sink_steady;

    sobel_gradient_direction u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned isqrt(int unsigned v);
        int unsigned res;
        int unsigned b;
        res = 0;
        b = 32'h4000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic predict_pixel(input logic [7:0] px, input logic sof);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned ax;
        int unsigned ay;
        int          gx;
        int          gy;
        logic [7:0]  top;
        logic [7:0]  mid;
        gradient_t   g;
        w = (width_reg < 3) ? 3 : (width_reg > MaxWidth) ? MaxWidth : width_reg;
        h = (height_reg < 3) ? 3 : (height_reg > MaxHeight) ? MaxHeight : height_reg;
        if (sof)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        top = far_row[c % MaxWidth];
        mid = near_row[c % MaxWidth];
        far_row[c % MaxWidth] = mid;
        near_row[c % MaxWidth] = px;
        for (int i = 0; i < 3; i++)
        begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px;
        if (c >= 2 && r >= 2 && c <= w - 1 && r <= h - 1)
        begin
            gx = (int'(win[2]) + 2*int'(win[5]) + int'(win[8]))
               - (int'(win[0]) + 2*int'(win[3]) + int'(win[6]));
            gy = (int'(win[0]) + 2*int'(win[1]) + int'(win[2]))
               - (int'(win[6]) + 2*int'(win[7]) + int'(win[8]));
            ay = (gy < 0) ? -gy : gy;
            ax = (gx < 0) ? -gx : gx;
            g.magnitude = MagW'(isqrt((ay*ay + ax*ax) * 256));
            if ((ay + ax)*(ay + ax) < 2*ax*ax || (ax == 0 && ay == 0))
                g.direction = DirHorizontal;
            else if (ay > ax && (ay - ax)*(ay - ax) > 2*ax*ax)
                g.direction = DirVertical;
            else if ((gx > 0 && gy > 0) || (gx < 0 && gy < 0))
                g.direction = DirDiagUp;
            else
                g.direction = DirDiagDown;
            g.row_end = (c == w - 1);
            g.frame_end = (c == w - 1 && r == h - 1);
            expected_q.push_back(g);
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic send_pixel(input logic [7:0] px, input logic sof);
        while (!src_steady && $urandom_range(99) < 23)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= sof;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_pixel(px, sof);
        pixel_count++;
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CfgDataW-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == RegImageWidth)
            width_reg = val & 32'h7FF;
        else
            height_reg = val & 32'h1FFF;
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h);
        wait_drain();
        write_reg(RegImageWidth, w);
        write_reg(RegImageHeight, h);
    endtask

    task automatic send_frame(input int mode);
        int unsigned w;
        int unsigned h;
        w = (width_reg < 3) ? 3 : (width_reg > MaxWidth) ? MaxWidth : width_reg;
        h = (height_reg < 3) ? 3 : (height_reg > MaxHeight) ? MaxHeight : height_reg;
        for (int unsigned i = 0; i < w*h; i++)
        begin
            case (mode)
                0: send_pixel(8'($urandom), i == 0);
                1: send_pixel($urandom_range(1) ? 8'hFF : 8'h00, i == 0);
                default: send_pixel(((i % w) < w/2) ? 8'h00 : 8'hFF, i == 0);
            endcase
        end
        frame_count++;
    endtask

    task automatic test_directed();
        set_geometry(3, 3);
        for (int i = 0; i < 9; i++)
            send_pixel(8'h00, i == 0);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 3 == 2) ? 8'hFF : 8'h00, i == 0);
        for (int i = 0; i < 9; i++)
            send_pixel((i < 3) ? 8'hFF : 8'h00, i == 0);
        for (int i = 0; i < 9; i++)
            send_pixel((i == 0 || i == 1 || i == 3) ? 8'hFF : 8'h00, i == 0);
        for (int i = 0; i < 9; i++)
            send_pixel((i == 1 || i == 2 || i == 5) ? 8'hFF : 8'h00, i == 0);
        frame_count += 5;
        set_geometry(0, 0);
        send_frame(1);
    endtask

    task automatic test_geometries();
        set_geometry(5, 4);
        send_frame(2);
        send_frame(0);
        set_geometry(2047, 8191);
        for (int i = 0; i < 40; i++)
            send_pixel(8'($urandom), i == 0);
        set_geometry(4, 3);
        send_frame(1);
    endtask

    task automatic test_random_frames();
        int w;
        int h;
        while (pixel_count < 900)
        begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            set_geometry(w, h);
            src_steady = ($urandom_range(3) == 0);
            repeat ($urandom_range(1, 3)) send_frame($urandom_range(2));
            for (int i = $urandom_range(0, 2*w); i > 0; i--)
                send_pixel(8'($urandom), 1'b0);
            if ($urandom_range(3) == 0)
                for (int i = 0; i < w + 2; i++)
                    send_pixel(8'($urandom), i == 0 || $urandom_range(15) == 0);
        end
        src_steady = 1'b0;
    endtask

    task automatic test_midframe_change();
        set_geometry(8, 6);
        for (int i = 0; i < 30; i++)
            send_pixel(8'($urandom), i == 0);
        wait_drain();
        write_reg(RegImageWidth, 4);
        write_reg(RegImageHeight, 3);
        for (int i = 0; i < 40; i++)
            send_pixel(8'($urandom), 1'b0);
        set_geometry(6, 5);
        send_frame(0);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= sink_steady || ($urandom_range(99) >= 23);
    end

    always @(posedge clk)
    begin
        gradient_t want;
        gradient_t got;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CycleLimit)
            begin
                $display("ERROR: cycle limit reached");
                $display("TEST FAILED");
                $finish;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                got.magnitude = m_axis_tdata[14:0];
                got.direction = m_axis_tdata[17:15];
                got.row_end   = m_axis_tlast;
                got.frame_end = m_axis_tuser;
                gradient_count++;
                if (expected_q.size() == 0)
                    report_mismatch("unexpected gradient beat");
                else
                begin
                    want = expected_q.pop_front();
                    if (got.magnitude !== want.magnitude)
                        report_mismatch($sformatf("magnitude %0d, expected %0d",
                            got.magnitude, want.magnitude));
                    if (got.direction !== want.direction)
                        report_mismatch($sformatf("direction %0d, expected %0d",
                            got.direction, want.direction));
                    if (got.row_end !== want.row_end)
                        report_mismatch($sformatf("row_end %b, expected %b",
                            got.row_end, want.row_end));
                    if (got.frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end %b, expected %b",
                            got.frame_end, want.frame_end));
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        pixel_count = 0;
        gradient_count = 0;
        frame_count = 0;
        cycle_count = 0;
        src_steady = 1'b0;
        sink_steady = 1'b0;
        col_pos = 0;
        row_pos = 0;
        width_reg = WidthReset;
        height_reg = HeightReset;
        for (int i = 0; i < 9; i++)
            win[i] = '0;
        for (int i = 0; i < MaxWidth; i++)
        begin
            near_row[i] = '0;
            far_row[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        sink_steady = 1'b1;
        test_geometries();
        sink_steady = 1'b0;
        test_midframe_change();
        test_random_frames();
        wait_drain();
        $display("Sent %0d pixels in %0d frames, checked %0d gradient beats.",
            pixel_count, frame_count, gradient_count);
        $display("Frames from 3x3 to 12x8, clamped and mid-frame geometry, stalls on both sides.");
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
